### hw/rtl/sync_header_sum_framer_macros.svh
`ifndef SYNC_HEADER_SUM_FRAMER_MACROS_SVH
`define SYNC_HEADER_SUM_FRAMER_MACROS_SVH

// Assertion helpers for the framer. Both forms compile to nothing for synthesis.
`ifndef SYNTHESIS
`define SHFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shfr assertion failed");
`define SHFR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shfr assertion failed");
`else
`define SHFR_ASSERT(label, clk, rst_n, prop)
`define SHFR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hw/rtl/shfr_pkg.sv
package shfr_pkg;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  command;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_frame;
    } rsp_item_t;

    // One classified job handed from the front end to the back end.
    // For a start job, data is the command; for a payload job it is the byte.
    // closes is set when the job ends with the checksum.
    typedef struct packed {
        logic        is_start;
        logic [7:0]  data;
        logic [15:0] length;
        logic        closes;
    } job_t;

endpackage

### hw/rtl/shfr_front.sv
`include "sync_header_sum_framer_macros.svh"

module shfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  shfr_pkg::req_item_t req_data,
    output logic                job_valid,
    input  logic                job_ready,
    output shfr_pkg::job_t      job_data
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic        is_start;
    logic        accept;

    assign is_start  = (req_data.req_type == shfr_pkg::REQ_START);
    assign req_ready = job_ready;
    assign accept    = req_valid && req_ready;

    // A payload byte with no open frame is taken and dropped here.
    assign job_valid = req_valid && (is_start || frame_open_reg);

    always_comb
    begin
        job_data.is_start = is_start;
        job_data.length   = req_data.payload_length;
        if (is_start)
        begin
            job_data.data   = req_data.command;
            job_data.closes = (req_data.payload_length == 16'd0);
        end
        else
        begin
            job_data.data   = req_data.payload_byte;
            job_data.closes = (remaining_reg == 16'd1);
        end
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        if (accept)
        begin
            if (is_start)
            begin
                remaining_next  = req_data.payload_length;
                frame_open_next = (req_data.payload_length != 16'd0);
            end
            else if (frame_open_reg)
            begin
                remaining_next  = remaining_reg - 16'd1;
                frame_open_next = (remaining_reg != 16'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= 16'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
        end
    end

    `SHFR_ASSERT_ALWAYS(a_open_matches_count, clk, frame_open_reg == (remaining_reg != 16'd0))
    `SHFR_ASSERT(a_drop_only_when_closed, clk, rst_n, (req_valid && !job_valid) |-> (!is_start && !frame_open_reg))

endmodule

### hw/rtl/shfr_queue.sv
`include "sync_header_sum_framer_macros.svh"

// Small job queue; DEPTH must be a power of two, at least 2.
module shfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  shfr_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output shfr_pkg::job_t pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    shfr_pkg::job_t  mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    `SHFR_ASSERT_ALWAYS(a_count_bounded, clk, count_reg <= CW'(DEPTH))
    `SHFR_ASSERT(a_count_grows, clk, rst_n, (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule

### hw/rtl/shfr_back.sv
`include "sync_header_sum_framer_macros.svh"

module shfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          frame_version,
    input  logic                job_valid,
    output logic                job_ready,
    input  shfr_pkg::job_t      job_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output shfr_pkg::rsp_item_t rsp_data
);

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_SYNC2,
        ST_VER,
        ST_CMD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_SUM
    } step_t;

    step_t               step_reg;
    step_t               step_after;
    logic [7:0]          sum_reg;
    logic [7:0]          sum_next;
    logic [7:0]          sum_base;
    logic                rsp_valid_reg;
    shfr_pkg::rsp_item_t rsp_data_reg;
    logic [7:0]          byte_cur;
    logic                last_cur;
    logic                done_cur;
    logic                slot_free;
    logic                fire;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign fire      = job_valid && slot_free;
    assign job_ready = fire && done_cur;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        byte_cur   = 8'd0;
        last_cur   = 1'b0;
        done_cur   = 1'b0;
        step_after = ST_FIRST;
        unique case (step_reg)
            ST_FIRST:
            begin
                if (job_data.is_start)
                begin
                    byte_cur   = shfr_pkg::SYNC_FIRST;
                    step_after = ST_SYNC2;
                end
                else
                begin
                    byte_cur   = job_data.data;
                    done_cur   = !job_data.closes;
                    step_after = ST_SUM;
                end
            end
            ST_SYNC2:
            begin
                byte_cur   = shfr_pkg::SYNC_SECOND;
                step_after = ST_VER;
            end
            ST_VER:
            begin
                byte_cur   = frame_version;
                step_after = ST_CMD;
            end
            ST_CMD:
            begin
                byte_cur   = job_data.data;
                step_after = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                byte_cur   = job_data.length[15:8];
                step_after = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                byte_cur   = job_data.length[7:0];
                done_cur   = !job_data.closes;
                step_after = ST_SUM;
            end
            ST_SUM:
            begin
                byte_cur = sum_reg;
                last_cur = 1'b1;
                done_cur = 1'b1;
            end
            default:
            begin
                done_cur = 1'b1;
            end
        endcase
    end

    // The first header byte restarts the sum, which drops any abandoned frame.
    assign sum_base = (step_reg == ST_FIRST && job_data.is_start) ? 8'd0 : sum_reg;
    assign sum_next = last_cur ? sum_reg : sum_base + byte_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_FIRST;
            sum_reg       <= 8'd0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else if (fire)
        begin
            step_reg                   <= done_cur ? ST_FIRST : step_after;
            sum_reg                    <= sum_next;
            rsp_valid_reg              <= 1'b1;
            rsp_data_reg.frame_byte    <= byte_cur;
            rsp_data_reg.last_of_frame <= last_cur;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    `SHFR_ASSERT(a_mid_job_has_head, clk, rst_n, (step_reg != ST_FIRST) |-> job_valid)
    `SHFR_ASSERT(a_sum_only_when_closing, clk, rst_n, (step_reg == ST_SUM) |-> job_data.closes)

endmodule

### hw/rtl/sync_header_sum_framer.sv
// Frame builder for 55 AA framed packets: sync bytes, version, command, 16-bit length,
// payload, and an 8-bit wrapping sum of all earlier frame bytes with last_of_frame set.
// The front end classifies each request (dropping payload bytes with no open frame) and
// queues it; the back end drives one byte per cycle into a registered output. A payload
// byte yields one output byte, two when it carries the closing checksum; a start request
// yields six output bytes, seven with a zero length. The single output register sets the
// rate: one byte per cycle when the sink is always ready. The QUEUE_DEPTH-entry queue
// (a power of two, at least 2) lets requests keep arriving while a header drains.
// frame_version is to be written through the cfg port only while the block is idle; the
// block itself does not enforce this. No clearing pass follows reset.
module sync_header_sum_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  shfr_pkg::req_item_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output shfr_pkg::rsp_item_t rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    logic           frame_version_reg;
    logic [7:0]     version_reg;
    logic           fj_valid;
    logic           fj_ready;
    shfr_pkg::job_t fj_data;
    logic           bj_valid;
    logic           bj_ready;
    shfr_pkg::job_t bj_data;

    assign cfg_ready = 1'b1;

    // frame_version_reg marks that the version register has seen a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg       <= 8'd0;
            frame_version_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            version_reg       <= cfg_data;
            frame_version_reg <= 1'b1;
        end
    end

    shfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    shfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    shfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_version (frame_version_reg ? version_reg : 8'd0),
        .job_valid     (bj_valid),
        .job_ready     (bj_ready),
        .job_data      (bj_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp_data      (rsp_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PRED           = -1;  // row is checked against the frame predictor
    localparam int N_DIRECTED     = 21;
    localparam int N_PHASES       = 5;
    localparam int ITEMS_PER_PASS = 36;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        shfr_pkg::req_item_t item;
        int                  cnt;
        logic [55:0]         want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    shfr_pkg::req_item_t req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    shfr_pkg::rsp_item_t rsp_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [7:0]          cfg_data;

    // Predicted framer state.
    logic [7:0]  exp_sum;
    logic [15:0] exp_left;
    logic        exp_open;
    logic [7:0]  exp_version;

    shfr_pkg::rsp_item_t expected_bytes [$];
    shfr_pkg::rsp_item_t oldest;
    stim_row_t           dir_tab [N_DIRECTED];

    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    bit          src_jitter = 1'b1;
    bit          sink_jitter = 1'b1;

    sync_header_sum_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic build_frame_bytes(input shfr_pkg::req_item_t it,
                                     output shfr_pkg::rsp_item_t outs[$]);
        logic [7:0] hdr [6];
        outs = {};
        if (it.req_type == shfr_pkg::REQ_START)
        begin
            hdr = '{shfr_pkg::SYNC_FIRST, shfr_pkg::SYNC_SECOND, exp_version, it.command,
                    it.payload_length[15:8], it.payload_length[7:0]};
            // A start always restarts the sum, abandoning any open frame.
            exp_sum = 8'h00;
            foreach (hdr[i])
            begin
                outs.push_back(shfr_pkg::rsp_item_t'{hdr[i], 1'b0});
                exp_sum += hdr[i];
            end
            if (it.payload_length == 16'h0000)
            begin
                outs.push_back(shfr_pkg::rsp_item_t'{exp_sum, 1'b1});
                exp_open = 1'b0;
                exp_left = 16'h0000;
                exp_sum  = 8'h00;
            end
            else
            begin
                exp_open = 1'b1;
                exp_left = it.payload_length;
            end
        end
        else if (exp_open)
        begin
            outs.push_back(shfr_pkg::rsp_item_t'{it.payload_byte, 1'b0});
            exp_sum  += it.payload_byte;
            exp_left -= 16'd1;
            if (exp_left == 16'h0000)
            begin
                outs.push_back(shfr_pkg::rsp_item_t'{exp_sum, 1'b1});
                exp_open = 1'b0;
                exp_sum  = 8'h00;
            end
        end
    endtask

    function automatic shfr_pkg::req_item_t rand_item(input logic kind);
        shfr_pkg::req_item_t it;
        it.req_type       = kind;
        it.command        = 8'($urandom);
        it.payload_length = 16'($urandom);
        it.payload_byte   = 8'($urandom);
        return it;
    endfunction

    // A known count of cnt bytes is taken from want, most significant byte first;
    // the seventh byte of a known row is always a closing checksum.
    task automatic send_item(input shfr_pkg::req_item_t it, input int cnt = PRED,
                             input logic [55:0] want = '0);
        shfr_pkg::rsp_item_t outs[$];
        req_valid <= 1'b1;
        req_data  <= it;
        do @(posedge clk); while (!req_ready);
        build_frame_bytes(it, outs);
        if (cnt == PRED)
        begin
            foreach (outs[i])
                expected_bytes.push_back(outs[i]);
        end
        else
        begin
            for (int k = 0; k < cnt; k++)
                expected_bytes.push_back(shfr_pkg::rsp_item_t'{want[55 - 8 * k -: 8], k == 6});
        end
        if (src_jitter && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic write_version(input logic [7:0] ver);
        req_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ver;
        do @(posedge clk); while (!cfg_ready);
        exp_version = ver;
        cfg_valid <= 1'b0;
    endtask

    // Mostly well formed frames with random content, plus stray bytes, abandoned
    // frames and the odd huge length that is cut short by the next start.
    task automatic random_frames(input int target);
        shfr_pkg::req_item_t it;
        int                  framed;
        int                  len;
        int                  n_pay;
        int                  pick;
        framed = 0;
        while (framed < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                framed++;
                send_item(rand_item(shfr_pkg::REQ_PAYLOAD));
            end
            else
            begin
                it   = rand_item(shfr_pkg::REQ_START);
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    len = 0;
                else if (pick < 80)
                    len = $urandom_range(1, 8);
                else if (pick < 92)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(0, 65535);
                it.payload_length = len[15:0];
                n_pay = len;
                if (len > 40)
                    n_pay = $urandom_range(0, 12);
                else if (len > 0 && $urandom_range(0, 9) == 0)
                    n_pay = $urandom_range(0, len - 1);
                send_item(it);
                framed++;
                repeat (n_pay)
                begin
                    send_item(rand_item(shfr_pkg::REQ_PAYLOAD));
                    framed++;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    framed++;
                    send_item(rand_item(shfr_pkg::REQ_PAYLOAD));
                end
            end
        end
    endtask

    // Receiver: random stall bursts, plus a long hold-off when asked for.
    initial
    begin
        rsp_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_jitter && $urandom_range(0, 7) == 0)
            begin
                rsp_ready  <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %h last %b",
                                          rsp_data.frame_byte, rsp_data.last_of_frame));
            else
            begin
                oldest = expected_bytes.pop_front();
                if (rsp_data.frame_byte !== oldest.frame_byte)
                    report_mismatch($sformatf("frame_byte %h, expected %h",
                                              rsp_data.frame_byte, oldest.frame_byte));
                if (rsp_data.last_of_frame !== oldest.last_of_frame)
                    report_mismatch($sformatf("last_of_frame %b, expected %b on byte %h",
                                              rsp_data.last_of_frame, oldest.last_of_frame,
                                              oldest.frame_byte));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] ver;
        dir_tab = '{
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, 0, '0},
            '{'{shfr_pkg::REQ_START,   8'h00, 16'h0000, 8'h00}, 7, 56'h55AA_0000_0000_FF},
            '{'{shfr_pkg::REQ_START,   8'hFF, 16'h0000, 8'hFF}, 7, 56'h55AA_00FF_0000_FE},
            '{'{shfr_pkg::REQ_START,   8'h5A, 16'h0001, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'hFF, 16'hFFFF, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_START,   8'h12, 16'h0003, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'h80}, PRED, '0},
            '{'{shfr_pkg::REQ_START,   8'h34, 16'h0002, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'h01}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'h77}, 0, '0},
            '{'{shfr_pkg::REQ_START,   8'hA5, 16'hFFFF, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_START,   8'hC3, 16'h8000, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'h55}, PRED, '0},
            '{'{shfr_pkg::REQ_START,   8'h00, 16'h0100, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_START,   8'h7E, 16'h0000, 8'h00}, 7, 56'h55AA_007E_0000_7D},
            '{'{shfr_pkg::REQ_START,   8'hFF, 16'h0002, 8'h00}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, PRED, '0},
            '{'{shfr_pkg::REQ_PAYLOAD, 8'h00, 16'h0000, 8'hFF}, PRED, '0}
        };

        exp_sum     = 8'h00;
        exp_left    = 16'h0000;
        exp_open    = 1'b0;
        exp_version = 8'h00;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows run with the version byte still at its reset value.
        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].cnt, dir_tab[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p == 0)
                ver = 8'hFF;
            else if (p == 2)
                ver = 8'h00;
            else
                ver = 8'($urandom_range(1, 254));
            write_version(ver);
            // The sink stops long enough for the input side to back up.
            if (p == 1)
                hold_left = HOLD_CYCLES;
            if (p == N_PHASES - 1)
            begin
                src_jitter  = 1'b0;
                sink_jitter = 1'b0;
            end
            random_frames(ITEMS_PER_PASS);
        end

        req_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
